// ===== hw/rtl/sorted_window_block_average_unit_defines.svh =====
// ----------------------------------------------------------------------------
// sorted window block average unit assertion macros
// concurrent assertion shorthands used by the checker file swba_checker
// ----------------------------------------------------------------------------
`ifndef SORTED_WINDOW_BLOCK_AVERAGE_UNIT_DEFINES_SVH
`define SORTED_WINDOW_BLOCK_AVERAGE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SWBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swba check failed");

// next-cycle implication, checked outside reset
`define SWBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swba check failed");

`endif

// ===== hw/rtl/swba_pkg.sv =====
// ----------------------------------------------------------------------------
// swba_pkg
// shared constants, types and state codes of the sorted window block average
// ----------------------------------------------------------------------------
package swba_pkg;

  localparam int RES_BLOCK_DEF   = 100;
  localparam int CUR_BLOCK_DEF   = 30;
  localparam int WINDOW_LEN_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int OUT_MEAN_W = 16;
  localparam int IN_SAMPLE_W = 16;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_START_RESET = 7'd40;

  localparam int ADDR_W = 3;
  localparam logic REG_WINDOW_START = 1'b0;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } swba_cell_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DRAIN   = 5'b00010,
    ST_DIV_RES = 5'b00100,
    ST_DIV_CUR = 5'b01000,
    ST_FINISH  = 5'b10000
  } swba_state_t;

endpackage

// ===== hw/rtl/sorted_window_block_average_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_window_block_average_unit
// trimmed-mean decimation of a resistance channel and block mean of a
// load-current channel
// ----------------------------------------------------------------------------
// in channel: one request per scan, taken when in_valid and in_ready are
//   high; in_ready is high only while idle
// out channel: one result per request, held in an output register until
//   out_ready; a new request is taken while a result still waits
// ordinary scan: the accept moves to ST_FINISH, which loads the result
//   register once the output register is free, then returns to idle
// each divide by a block length is a reciprocal multiply in swba_div
// closing a resistance block shifts the chain down through rank
//   start + WINDOW_LEN - 1 (at most RES_BLOCK - 1) to sum the window, then
//   divides; closing both blocks together divides twice
// reset empties the chain (valid bits), clears counters and the current
//   sum and sets window_start_rank to 40
// a stalled receiver holds the output register; with a second result ready
//   the block takes no request until the first one leaves
// ----------------------------------------------------------------------------
module sorted_window_block_average_unit
  import swba_pkg::*;
#(
  parameter int RES_BLOCK   = RES_BLOCK_DEF,
  parameter int CUR_BLOCK   = CUR_BLOCK_DEF,
  parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_SAMPLE_W-1:0] in_resistance_sample,
  input  logic [IN_SAMPLE_W-1:0] in_current_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_resistance_valid,
  output logic [OUT_MEAN_W-1:0]  out_resistance_mean,
  output logic                   out_current_valid,
  output logic [OUT_MEAN_W-1:0]  out_current_mean,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int CNT_W = $clog2(RES_BLOCK);
  localparam int CC_W  = (CUR_BLOCK > 1) ? $clog2(CUR_BLOCK) : 1;
  localparam int RSW   = SAMPLE_BITS + $clog2(WINDOW_LEN + 1);
  localparam int CSW   = SAMPLE_BITS + $clog2(CUR_BLOCK + 1);
  localparam int DW    = (RSW > CSW) ? RSW : CSW;
  localparam int SW    = (CNT_W >= CFG_W) ? CNT_W + 1 : CFG_W + 1;
  localparam int MAX_START = RES_BLOCK - WINDOW_LEN;
  localparam int SH_W   = $clog2(2 * DW + 1);
  localparam int RES_SH = DW + $clog2(WINDOW_LEN);
  localparam int CUR_SH = DW + $clog2(CUR_BLOCK);
  localparam logic [63:0] RES_RECIP =
    ((64'd1 << RES_SH) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN);
  localparam logic [63:0] CUR_RECIP =
    ((64'd1 << CUR_SH) + 64'(CUR_BLOCK - 1)) / 64'(CUR_BLOCK);

  // configuration
  logic [CFG_W-1:0] wsr_r, wsr_nxt;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_START);

  always_comb begin
    wsr_nxt = wsr_r;
    if (cfg_wr) begin
      wsr_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW_START) begin
      prdata = 32'(wsr_r);
    end
  end

  // control state
  swba_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic [CC_W-1:0]      cur_cnt_r, cur_cnt_nxt;
  logic [CSW-1:0]       cur_sum_r, cur_sum_nxt;
  logic [CSW-1:0]       cur_div_r, cur_div_nxt;
  logic [RSW-1:0]       res_sum_r, res_sum_nxt;
  logic [CNT_W-1:0]     drain_cnt_r, drain_cnt_nxt;
  logic                 res_pend_r, res_pend_nxt;
  logic                 cur_pend_r, cur_pend_nxt;
  logic                 div_go_r, div_go_nxt;
  logic [SAMPLE_BITS-1:0] res_mean_r, res_mean_nxt;
  logic [SAMPLE_BITS-1:0] cur_mean_r, cur_mean_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_rv_r, out_rv_nxt;
  logic                  out_cv_r, out_cv_nxt;
  logic [OUT_MEAN_W-1:0] out_rm_r, out_rm_nxt;
  logic [OUT_MEAN_W-1:0] out_cm_r, out_cm_nxt;

  logic                   accept;
  logic                   res_last;
  logic                   cur_last;
  logic                   drain_last;
  logic [SAMPLE_BITS-1:0] r_smp;
  logic [SAMPLE_BITS-1:0] c_smp;
  logic [SW-1:0]          start_w;
  logic [CNT_W-1:0]       start_idx;
  logic [CNT_W-1:0]       end_idx;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign r_smp    = in_resistance_sample[SAMPLE_BITS-1:0];
  assign c_smp    = in_current_sample[SAMPLE_BITS-1:0];
  assign res_last = (res_cnt_r == CNT_W'(RES_BLOCK - 1));
  assign cur_last = (cur_cnt_r == CC_W'(CUR_BLOCK - 1));

  // window start saturates so the window stays inside the block
  assign start_w    = (SW'(wsr_r) > SW'(MAX_START)) ? SW'(MAX_START) : SW'(wsr_r);
  assign start_idx  = start_w[CNT_W-1:0];
  assign end_idx    = CNT_W'(start_w + SW'(WINDOW_LEN - 1));
  assign drain_last = (drain_cnt_r == end_idx);

  // sorting chain
  swba_cell_ctrl_t        cell_ctrl;
  logic [SAMPLE_BITS-1:0] cell_val  [RES_BLOCK];
  logic                   cell_vld  [RES_BLOCK];
  logic                   cell_take [RES_BLOCK];

  assign cell_ctrl.insert = accept;
  assign cell_ctrl.shift  = (state_r == ST_DRAIN);
  assign cell_ctrl.clear  = (state_r == ST_DRAIN) && drain_last;

  for (genvar i = 0; i < RES_BLOCK; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] p_val;
    logic                   p_vld;
    logic                   p_take;
    logic [SAMPLE_BITS-1:0] u_val;
    logic                   u_vld;

    if (i == 0) begin : g_first
      assign p_val  = '0;
      assign p_vld  = 1'b0;
      assign p_take = 1'b0;
    end else begin : g_mid
      assign p_val  = cell_val[i-1];
      assign p_vld  = cell_vld[i-1];
      assign p_take = cell_take[i-1];
    end

    if (i == RES_BLOCK - 1) begin : g_top
      assign u_val = '0;
      assign u_vld = 1'b0;
    end else begin : g_low
      assign u_val = cell_val[i+1];
      assign u_vld = cell_vld[i+1];
    end

    swba_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .sample   (r_smp),
      .prev_val (p_val),
      .prev_vld (p_vld),
      .prev_take(p_take),
      .up_val   (u_val),
      .up_vld   (u_vld),
      .val      (cell_val[i]),
      .vld      (cell_vld[i]),
      .take     (cell_take[i])
    );
  end

  // shared divider
  logic [DW-1:0]   div_dividend;
  logic [DW:0]     div_recip;
  logic [SH_W-1:0] div_shift;
  logic            div_done;
  logic [DW-1:0]   div_q;

  assign div_dividend = (state_r == ST_DIV_RES) ? DW'(res_sum_r) : DW'(cur_div_r);
  assign div_recip    = (state_r == ST_DIV_RES) ? RES_RECIP[DW:0] : CUR_RECIP[DW:0];
  assign div_shift    = (state_r == ST_DIV_RES) ? SH_W'(RES_SH) : SH_W'(CUR_SH);

  swba_div #(
    .DW  (DW),
    .SH_W(SH_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go_r),
    .dividend(div_dividend),
    .recip   (div_recip),
    .shift   (div_shift),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    res_cnt_nxt   = res_cnt_r;
    cur_cnt_nxt   = cur_cnt_r;
    cur_sum_nxt   = cur_sum_r;
    cur_div_nxt   = cur_div_r;
    res_sum_nxt   = res_sum_r;
    drain_cnt_nxt = drain_cnt_r;
    res_pend_nxt  = res_pend_r;
    cur_pend_nxt  = cur_pend_r;
    div_go_nxt    = 1'b0;
    res_mean_nxt  = res_mean_r;
    cur_mean_nxt  = cur_mean_r;
    out_valid_nxt = out_valid_r;
    out_rv_nxt    = out_rv_r;
    out_cv_nxt    = out_cv_r;
    out_rm_nxt    = out_rm_r;
    out_cm_nxt    = out_cm_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_pend_nxt = res_last;
          cur_pend_nxt = cur_last;
          res_cnt_nxt  = res_last ? '0 : CNT_W'(res_cnt_r + 1'b1);
          if (cur_last) begin
            cur_div_nxt = CSW'(cur_sum_r + CSW'(c_smp));
            cur_sum_nxt = '0;
            cur_cnt_nxt = '0;
          end else begin
            cur_sum_nxt = CSW'(cur_sum_r + CSW'(c_smp));
            cur_cnt_nxt = CC_W'(cur_cnt_r + 1'b1);
          end
          if (res_last) begin
            state_nxt     = ST_DRAIN;
            drain_cnt_nxt = '0;
            res_sum_nxt   = '0;
          end else if (cur_last) begin
            state_nxt  = ST_DIV_CUR;
            div_go_nxt = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_DRAIN: begin
        // cell 0 holds rank drain_cnt of the full block
        if (drain_cnt_r >= start_idx) begin
          res_sum_nxt = RSW'(res_sum_r + RSW'(cell_val[0]));
        end
        drain_cnt_nxt = CNT_W'(drain_cnt_r + 1'b1);
        if (drain_last) begin
          state_nxt  = ST_DIV_RES;
          div_go_nxt = 1'b1;
        end
      end
      ST_DIV_RES: begin
        if (div_done) begin
          res_mean_nxt = div_q[SAMPLE_BITS-1:0];
          if (cur_pend_r) begin
            state_nxt  = ST_DIV_CUR;
            div_go_nxt = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_DIV_CUR: begin
        if (div_done) begin
          cur_mean_nxt = div_q[SAMPLE_BITS-1:0];
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = res_pend_r;
          out_cv_nxt    = cur_pend_r;
          out_rm_nxt    = res_pend_r ? OUT_MEAN_W'(res_mean_r) : '0;
          out_cm_nxt    = cur_pend_r ? OUT_MEAN_W'(cur_mean_r) : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsr_r       <= WINDOW_START_RESET;
      state_r     <= ST_IDLE;
      res_cnt_r   <= '0;
      cur_cnt_r   <= '0;
      cur_sum_r   <= '0;
      drain_cnt_r <= '0;
      res_pend_r  <= 1'b0;
      cur_pend_r  <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wsr_r       <= wsr_nxt;
      state_r     <= state_nxt;
      res_cnt_r   <= res_cnt_nxt;
      cur_cnt_r   <= cur_cnt_nxt;
      cur_sum_r   <= cur_sum_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      res_pend_r  <= res_pend_nxt;
      cur_pend_r  <= cur_pend_nxt;
      div_go_r    <= div_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_div_r  <= cur_div_nxt;
    res_sum_r  <= res_sum_nxt;
    res_mean_r <= res_mean_nxt;
    cur_mean_r <= cur_mean_nxt;
    out_rv_r   <= out_rv_nxt;
    out_cv_r   <= out_cv_nxt;
    out_rm_r   <= out_rm_nxt;
    out_cm_r   <= out_cm_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_resistance_valid = out_rv_r;
  assign out_resistance_mean  = out_rm_r;
  assign out_current_valid    = out_cv_r;
  assign out_current_mean     = out_cm_r;

endmodule

// ===== hw/rtl/swba_cell.sv =====
// ----------------------------------------------------------------------------
// swba_cell
// one cell of the sorting chain: holds one sample and its valid bit
// ----------------------------------------------------------------------------
module swba_cell
  import swba_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swba_cell_ctrl_t        ctrl,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] prev_val,
  input  logic                   prev_vld,
  input  logic                   prev_take,
  input  logic [SAMPLE_BITS-1:0] up_val,
  input  logic                   up_vld,
  output logic [SAMPLE_BITS-1:0] val,
  output logic                   vld,
  output logic                   take
);

  logic [SAMPLE_BITS-1:0] val_r, val_nxt;
  logic                   vld_r, vld_nxt;

  // an equal sample goes after the stored one
  assign take = !vld_r || (val_r > sample);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctrl.clear) begin
      vld_nxt = 1'b0;
    end else if (ctrl.shift) begin
      val_nxt = up_val;
      vld_nxt = up_vld;
    end else if (ctrl.insert) begin
      if (prev_take) begin
        val_nxt = prev_val;
        vld_nxt = prev_vld;
      end else if (take) begin
        val_nxt = sample;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

// ===== hw/rtl/swba_div.sv =====
// ----------------------------------------------------------------------------
// swba_div
// division by a block length through a reciprocal multiply; the product
// and done are registered on start
// ----------------------------------------------------------------------------
module swba_div
  import swba_pkg::*;
#(
  parameter int DW   = 24,
  parameter int SH_W = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  logic [DW:0]     recip,
  input  logic [SH_W-1:0] shift,
  output logic            done,
  output logic [DW-1:0]   quotient
);

  localparam int PW = 2 * DW + 1;

  logic [PW-1:0] prod_r, prod_nxt;
  logic          done_r, done_nxt;

  // recip is the rounded-up reciprocal scaled by 2**shift, exact for any
  // dividend of DW bits
  always_comb begin
    prod_nxt = prod_r;
    done_nxt = start;
    if (start) begin
      prod_nxt = PW'(dividend) * PW'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign done     = done_r;
  assign quotient = DW'(prod_r >> shift);

endmodule

// ===== hw/rtl/swba_checker.sv =====
// ----------------------------------------------------------------------------
// swba_checker
// port-level checks of the sorted window block average unit
// ----------------------------------------------------------------------------
`include "sorted_window_block_average_unit_defines.svh"

module swba_checker
  import swba_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_resistance_valid,
  input logic [OUT_MEAN_W-1:0]  out_resistance_mean,
  input logic                   out_current_valid,
  input logic [OUT_MEAN_W-1:0]  out_current_mean
);

  // a stalled result keeps its payload
  `SWBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_resistance_mean) && $stable(out_current_mean))

  // a mean without its flag reads zero
  `SWBA_ASSERT_NOW(a_res_zero, out_valid && !out_resistance_valid,
    out_resistance_mean == '0)
  `SWBA_ASSERT_NOW(a_cur_zero, out_valid && !out_current_valid,
    out_current_mean == '0)

  // one request at a time: ready drops after every accept
  `SWBA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind sorted_window_block_average_unit swba_checker u_swba_checker (.*);

// ===== tb/sorted_window_block_average_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_window_block_average_unit_tb
// drives scans through the unit and checks every result against a local
// trimmed-mean and block-mean predictor, across several window start ranks
// and with random idle bursts on both the request and result sides
// ----------------------------------------------------------------------------
module sorted_window_block_average_unit_tb;
  import swba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] WINDOW_START_ADDR = ADDR_W'(4 * REG_WINDOW_START);
  localparam int unsigned SAMPLE_MASK = (1 << SAMPLE_BITS_DEF) - 1;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [IN_SAMPLE_W-1:0] res;
    logic [IN_SAMPLE_W-1:0] cur;
  } scan_t;

  typedef struct packed {
    logic                  res_valid;
    logic [OUT_MEAN_W-1:0] res_mean;
    logic                  cur_valid;
    logic [OUT_MEAN_W-1:0] cur_mean;
  } means_t;

  typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGE, MIX_TOP} sample_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_SAMPLE_W-1:0] in_resistance_sample = '0;
  logic [IN_SAMPLE_W-1:0] in_current_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_resistance_valid;
  logic [OUT_MEAN_W-1:0] out_resistance_mean;
  logic out_current_valid;
  logic [OUT_MEAN_W-1:0] out_current_mean;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  logic [IN_SAMPLE_W-1:0] ladder [RES_BLOCK_DEF];
  int unsigned ladder_fill = 0;
  int unsigned cur_acc = 0;
  int unsigned cur_fill = 0;
  logic [CFG_W-1:0] rank_sel = WINDOW_START_RESET;

  scan_t scan_q[$];
  means_t pending_means[$];

  int scans_queued = 0;
  int scans_taken = 0;
  int results_seen = 0;
  int res_windows = 0;
  int cur_blocks = 0;
  int rank_writes = 0;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;

  sorted_window_block_average_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_resistance_sample (in_resistance_sample),
    .in_current_sample    (in_current_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_resistance_valid (out_resistance_valid),
    .out_resistance_mean  (out_resistance_mean),
    .out_current_valid    (out_current_valid),
    .out_current_mean     (out_current_mean),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #1 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // insert the new resistance code in order, close blocks that complete
  function automatic means_t scan_to_means(input logic [IN_SAMPLE_W-1:0] r_raw,
                                           input logic [IN_SAMPLE_W-1:0] c_raw);
    means_t m;
    logic [IN_SAMPLE_W-1:0] r;
    int unsigned pos;
    int unsigned start;
    int unsigned wsum;
    m = '0;
    r = IN_SAMPLE_W'(r_raw & SAMPLE_MASK);
    pos = ladder_fill;
    // equal codes stay ahead of the new one
    while (pos > 0 && ladder[pos-1] > r) begin
      ladder[pos] = ladder[pos-1];
      pos--;
    end
    ladder[pos] = r;
    ladder_fill++;
    if (ladder_fill >= RES_BLOCK_DEF) begin
      start = rank_sel;
      if (start + WINDOW_LEN_DEF > RES_BLOCK_DEF) begin
        start = RES_BLOCK_DEF - WINDOW_LEN_DEF;
      end
      wsum = 0;
      for (int k = 0; k < WINDOW_LEN_DEF; k++) begin
        wsum += ladder[start+k];
      end
      m.res_valid = 1'b1;
      m.res_mean = OUT_MEAN_W'(wsum / WINDOW_LEN_DEF);
      ladder_fill = 0;
    end
    cur_acc += c_raw & SAMPLE_MASK;
    cur_fill++;
    if (cur_fill >= CUR_BLOCK_DEF) begin
      m.cur_valid = 1'b1;
      m.cur_mean = OUT_MEAN_W'(cur_acc / CUR_BLOCK_DEF);
      cur_acc = 0;
      cur_fill = 0;
    end
    return m;
  endfunction

  task automatic push_scan(input logic [IN_SAMPLE_W-1:0] r, input logic [IN_SAMPLE_W-1:0] c);
    scan_t s;
    s.res = r;
    s.cur = c;
    scan_q.push_back(s);
    scans_queued++;
  endtask

  task automatic queue_directed_scans();
    push_scan(16'h0000, 16'h0000);
    push_scan(16'hFFFF, 16'hFFFF);
    push_scan(16'h0000, 16'hFFFF);
    push_scan(16'hFFFF, 16'h0000);
    push_scan(16'h5555, 16'hAAAA);
    push_scan(16'hAAAA, 16'h5555);
    push_scan(16'h5555, 16'hAAAA);
    push_scan(16'hAAAA, 16'h5555);
    // equal codes in a row
    push_scan(16'd1000, 16'd1);
    push_scan(16'd1000, 16'd2);
    push_scan(16'd1000, 16'd3);
    // falling codes each land below the earlier falling codes
    for (int i = 0; i < 9; i++) begin
      push_scan(16'(60000 - 5000 * i), 16'(7000 * i));
    end
    push_scan(16'd1000, 16'hFFFE);
    push_scan(16'd1, 16'd1);
    push_scan(16'hFFFE, 16'h8000);
    push_scan(16'h8000, 16'h7FFF);
    push_scan(16'h7FFF, 16'hFFFF);
  endtask

  task automatic queue_random_scans(input int n_scans);
    sample_mix_t mix;
    int base;
    logic [IN_SAMPLE_W-1:0] r;
    logic [IN_SAMPLE_W-1:0] c;
    mix = MIX_FULL;
    base = 0;
    for (int i = 0; i < n_scans; i++) begin
      if (i % 25 == 0) begin
        mix = sample_mix_t'($urandom_range(0, 3));
        base = $urandom_range(0, 65535);
      end
      case (mix)
        MIX_NARROW: begin
          // many ties around one level
          r = 16'(base + $urandom_range(0, 3));
          c = 16'(base ^ $urandom_range(0, 15));
        end
        MIX_EDGE: begin
          r = $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 1))
                                   : 16'($urandom_range(0, 1));
          c = $urandom_range(0, 1) ? 16'(16'hFFFF - $urandom_range(0, 1))
                                   : 16'($urandom_range(0, 1));
        end
        MIX_TOP: begin
          r = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'hFFFF;
          c = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'hFFFF;
        end
        default: begin
          r = 16'($urandom());
          c = 16'($urandom());
        end
      endcase
      push_scan(r, c);
    end
  endtask

  task automatic write_window_start(input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_START_ADDR;
    // junk above the register width must be dropped
    pwdata <= ($urandom() & ~32'h7F) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rank_sel = val;
    rank_writes++;
  endtask

  task automatic wait_all_done();
    while (scans_taken != scans_queued || pending_means.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic write_rank, input logic [CFG_W-1:0] rank,
                           input int n_scans, input int s_pct, input int r_pct);
    wait_all_done();
    if (write_rank) begin
      write_window_start(rank);
    end
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    queue_random_scans(n_scans);
  endtask

  always @(posedge clk) begin : scan_driver
    scan_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_means.push_back(scan_to_means(in_resistance_sample, in_current_sample));
        scans_taken++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 9);
        end
      end
      if (in_valid && !in_ready) begin
        // request held until taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (scan_q.size() > 0) begin
        nxt = scan_q.pop_front();
        in_resistance_sample <= nxt.res;
        in_current_sample <= nxt.cur;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : mean_monitor
    means_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_means.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no scan waiting", results_seen));
        end else begin
          want = pending_means.pop_front();
          if (out_resistance_valid !== want.res_valid) begin
            flag_error($sformatf("result %0d resistance_valid %b, want %b", results_seen,
                                 out_resistance_valid, want.res_valid));
          end
          if (out_resistance_mean !== want.res_mean) begin
            flag_error($sformatf("result %0d resistance_mean %0d, want %0d", results_seen,
                                 out_resistance_mean, want.res_mean));
          end
          if (out_current_valid !== want.cur_valid) begin
            flag_error($sformatf("result %0d current_valid %b, want %b", results_seen,
                                 out_current_valid, want.cur_valid));
          end
          if (out_current_mean !== want.cur_mean) begin
            flag_error($sformatf("result %0d current_mean %0d, want %0d", results_seen,
                                 out_current_mean, want.cur_mean));
          end
          if (want.res_valid) res_windows++;
          if (want.cur_valid) cur_blocks++;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        recv_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_stall_pct = 30;
    queue_directed_scans();
    // first window runs on the reset rank
    run_phase(1'b0, WINDOW_START_RESET, 275, 30, 30);
    run_phase(1'b1, 7'd0, 250, 0, 0);
    run_phase(1'b1, 7'd90, 250, 50, 10);
    // ranks past the end saturate to the last full window
    run_phase(1'b1, 7'd127, 200, 10, 50);
    run_phase(1'b1, 7'd91, 100, 40, 40);
    repeat (3) run_phase(1'b1, CFG_W'($urandom_range(0, 127)), 150, 25, 25);
    run_phase(1'b1, WINDOW_START_RESET, 100, 0, 0);
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d scans: %0d resistance windows, %0d current blocks",
             results_seen, res_windows, cur_blocks);
    $display("window start rank written %0d times, mismatches %0d", rank_writes,
             mismatch_count);
    if (mismatch_count == 0 && pending_means.size() == 0) begin
      $display("sorted_window_block_average_unit_tb OK");
    end else begin
      $display("sorted_window_block_average_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d results still expected", pending_means.size());
    $display("sorted_window_block_average_unit_tb NOT OK");
    $finish;
  end

endmodule
